### rtl/dmrq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmrq_pkg
// Shared types, constants and helpers of the delimited message receive queue.
// ----------------------------------------------------------------------------
package dmrq_pkg;

  localparam int MAX_MESSAGES = 4;
  localparam int MAX_CHARS    = 32;

  localparam int SLOT_W    = $clog2(MAX_MESSAGES);
  localparam int LEN_W     = $clog2(MAX_CHARS);
  localparam int CNT_W     = $clog2(MAX_MESSAGES + 1);
  localparam int MEM_DEPTH = MAX_MESSAGES * MAX_CHARS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int WAIT_W    = 5;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic       ACT_LINE = 1'b0;
  localparam logic       ACT_READ = 1'b1;

  localparam logic [1:0] ST_BYTE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_NONE  = 2'd2;

  localparam logic       CFG_START = 1'b0;
  localparam logic       CFG_END   = 1'b1;

  localparam logic [7:0] START_RESET = 8'd42;
  localparam logic [7:0] END_RESET   = 8'd36;

  typedef struct packed {
    logic       is_read;
    logic       is_start;
    logic       is_end;
    logic [7:0] data;
  } cmd_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] slot);
    if (slot == SLOT_W'(MAX_MESSAGES - 1)) begin
      return '0;
    end
    return slot + SLOT_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] text_addr(input logic [SLOT_W-1:0] slot,
                                                  input logic [LEN_W-1:0] idx);
    return ADDR_W'(slot) * ADDR_W'(MAX_CHARS) + ADDR_W'(idx);
  endfunction

endpackage

### rtl/delimited_message_receive_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_message_receive_queue_top
// Frame line bytes into a ring of message slots and read messages back out.
// ----------------------------------------------------------------------------
// Items with tuser 0 carry a line byte: the back end takes one whenever it is
// idle and produces no result. An item with tuser 1 reads the oldest message:
// an empty queue or an empty message gives one result; a message of n bytes
// gives n results, the first fetched through the registered read port of the
// message text memory and then one byte a cycle while the output is not
// stalled. Commands run strictly in order, so items behind a read wait in the
// two-entry command queue until the read-out ends. No clearing pass runs
// after reset.
module delimited_message_receive_queue_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] line_byte
  input  logic        s_tuser,   // [0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] message_byte, [12:8] messages_waiting
  output logic [1:0]  m_tuser,   // [1:0] status
  output logic        m_tlast
);

  dmrq_pkg::cmd_t              front_cmd;
  dmrq_pkg::cmd_t              back_cmd;
  logic                        q_full;
  logic                        q_valid;
  logic                        back_ready;
  logic [7:0]                  out_byte;
  logic [dmrq_pkg::WAIT_W-1:0] out_waiting;

  assign s_tready = !q_full;

  dmrq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .action    (s_tuser),
    .line_byte (s_tdata),
    .cmd       (front_cmd)
  );

  dmrq_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid && !q_full),
    .push_cmd  (front_cmd),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (back_ready),
    .pop_cmd   (back_cmd)
  );

  dmrq_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (q_valid),
    .cmd         (back_cmd),
    .cmd_ready   (back_ready),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_status  (m_tuser),
    .out_byte    (out_byte),
    .out_last    (m_tlast),
    .out_waiting (out_waiting)
  );

  assign m_tdata = {3'b000, out_waiting, out_byte};

endmodule

### rtl/dmrq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmrq_front
// Hold the marker registers and classify each input item into a command.
// ----------------------------------------------------------------------------
module dmrq_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              action,
  input  logic [7:0]        line_byte,
  output dmrq_pkg::cmd_t    cmd
);

  logic [7:0] start_marker;
  logic [7:0] end_marker;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= dmrq_pkg::START_RESET;
      end_marker   <= dmrq_pkg::END_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dmrq_pkg::CFG_START: start_marker <= cfg_data;
        dmrq_pkg::CFG_END:   end_marker   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cmd.is_read  = (action == dmrq_pkg::ACT_READ);
    cmd.is_start = (line_byte == start_marker);
    cmd.is_end   = (line_byte == end_marker);
    cmd.data     = line_byte;
  end

endmodule

### rtl/dmrq_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmrq_cmd_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module dmrq_cmd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dmrq_pkg::cmd_t    push_cmd,
  output logic              full,
  output logic              pop_valid,
  input  logic              pop,
  output dmrq_pkg::cmd_t    pop_cmd
);

  dmrq_pkg::cmd_t                 entry [dmrq_pkg::QUEUE_DEPTH];
  logic [dmrq_pkg::QPTR_W-1:0]    wr_ptr;
  logic [dmrq_pkg::QPTR_W-1:0]    rd_ptr;
  logic [dmrq_pkg::QCNT_W-1:0]    count;
  logic                           do_pop;

  assign full      = (count == dmrq_pkg::QCNT_W'(dmrq_pkg::QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_cmd   = entry[rd_ptr];
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == dmrq_pkg::QPTR_W'(dmrq_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + dmrq_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == dmrq_pkg::QPTR_W'(dmrq_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + dmrq_pkg::QPTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + dmrq_pkg::QCNT_W'(1);
      end else if (!push && do_pop) begin
        count <= count - dmrq_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

### rtl/dmrq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmrq_back
// Execute commands: frame messages into slots and stream out the oldest one.
// ----------------------------------------------------------------------------
module dmrq_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  input  dmrq_pkg::cmd_t              cmd,
  output logic                        cmd_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic [7:0]                  out_byte,
  output logic                        out_last,
  output logic [dmrq_pkg::WAIT_W-1:0] out_waiting
);

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_STREAM = 1'b1;

  logic [7:0]                  text_mem [dmrq_pkg::MEM_DEPTH];
  logic [7:0]                  mem_q;
  logic [dmrq_pkg::LEN_W-1:0]  msg_len [dmrq_pkg::MAX_MESSAGES];

  logic                        state, state_next;
  logic [dmrq_pkg::SLOT_W-1:0] fill_slot, fill_slot_next;
  logic [dmrq_pkg::SLOT_W-1:0] drain_slot, drain_slot_next;
  logic [dmrq_pkg::CNT_W-1:0]  queued, queued_next;
  logic                        receiving, receiving_next;
  logic [dmrq_pkg::LEN_W-1:0]  fill_len, fill_len_next;
  logic [dmrq_pkg::LEN_W-1:0]  rd_idx, rd_idx_next;
  logic [dmrq_pkg::LEN_W-1:0]  rd_len, rd_len_next;

  logic                        out_valid_next;
  logic                        out_load;
  logic [1:0]                  out_status_next;
  logic [7:0]                  out_byte_next;
  logic                        out_last_next;
  logic [dmrq_pkg::WAIT_W-1:0] out_waiting_next;

  logic                        wr_en;
  logic [dmrq_pkg::ADDR_W-1:0] wr_addr;
  logic                        rd_en;
  logic [dmrq_pkg::ADDR_W-1:0] rd_addr;
  logic                        len_we;

  logic                        out_free;
  logic [dmrq_pkg::LEN_W-1:0]  cur_len;
  logic [dmrq_pkg::LEN_W:0]    fill_inc;
  logic [dmrq_pkg::LEN_W:0]    idx_inc;
  logic                        final_byte;
  logic                        has_room;

  assign out_free = !out_valid || out_ready;
  assign cur_len  = msg_len[drain_slot];
  assign fill_inc = {1'b0, fill_len} + (dmrq_pkg::LEN_W + 1)'(1);
  assign idx_inc  = {1'b0, rd_idx} + (dmrq_pkg::LEN_W + 1)'(1);
  assign final_byte = (idx_inc == {1'b0, rd_len});
  assign has_room = (queued < dmrq_pkg::CNT_W'(dmrq_pkg::MAX_MESSAGES));

  always_comb begin
    state_next       = state;
    fill_slot_next   = fill_slot;
    drain_slot_next  = drain_slot;
    queued_next      = queued;
    receiving_next   = receiving;
    fill_len_next    = fill_len;
    rd_idx_next      = rd_idx;
    rd_len_next      = rd_len;
    cmd_ready        = 1'b0;
    out_load         = 1'b0;
    out_status_next  = dmrq_pkg::ST_BYTE;
    out_byte_next    = mem_q;
    out_last_next    = 1'b0;
    out_waiting_next = dmrq_pkg::WAIT_W'(queued);
    wr_en            = 1'b0;
    wr_addr          = dmrq_pkg::text_addr(fill_slot, fill_len);
    rd_en            = 1'b0;
    rd_addr          = dmrq_pkg::text_addr(drain_slot, '0);
    len_we           = 1'b0;

    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.is_read) begin
            if (queued == '0) begin
              if (out_free) begin
                cmd_ready        = 1'b1;
                out_load         = 1'b1;
                out_status_next  = dmrq_pkg::ST_NONE;
                out_byte_next    = '0;
                out_last_next    = 1'b1;
                out_waiting_next = '0;
              end
            end else if (cur_len == '0) begin
              if (out_free) begin
                cmd_ready        = 1'b1;
                out_load         = 1'b1;
                out_status_next  = dmrq_pkg::ST_EMPTY;
                out_byte_next    = '0;
                out_last_next    = 1'b1;
                out_waiting_next = dmrq_pkg::WAIT_W'(queued - dmrq_pkg::CNT_W'(1));
                drain_slot_next  = dmrq_pkg::next_slot(drain_slot);
                queued_next      = queued - dmrq_pkg::CNT_W'(1);
              end
            end else begin
              // fetch the first byte, then stream
              cmd_ready   = 1'b1;
              rd_en       = 1'b1;
              rd_idx_next = '0;
              rd_len_next = cur_len;
              state_next  = S_STREAM;
            end
          end else begin
            cmd_ready = 1'b1;
            if (cmd.is_start && has_room) begin
              receiving_next = 1'b1;
              fill_len_next  = '0;
            end else if (cmd.is_end) begin
              if (receiving) begin
                len_we         = 1'b1;
                fill_slot_next = dmrq_pkg::next_slot(fill_slot);
                if (has_room) begin
                  queued_next = queued + dmrq_pkg::CNT_W'(1);
                end
                receiving_next = 1'b0;
              end
            end else if (receiving) begin
              wr_en = 1'b1;
              // drop the message once it reaches the slot size
              if (fill_inc >= (dmrq_pkg::LEN_W + 1)'(dmrq_pkg::MAX_CHARS)) begin
                fill_len_next  = '0;
                receiving_next = 1'b0;
              end else begin
                fill_len_next = fill_inc[dmrq_pkg::LEN_W-1:0];
              end
            end
          end
        end
      end
      S_STREAM: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_status_next = dmrq_pkg::ST_BYTE;
          out_byte_next   = mem_q;
          out_last_next   = final_byte;
          if (final_byte) begin
            out_waiting_next = dmrq_pkg::WAIT_W'(queued - dmrq_pkg::CNT_W'(1));
            drain_slot_next  = dmrq_pkg::next_slot(drain_slot);
            queued_next      = queued - dmrq_pkg::CNT_W'(1);
            state_next       = S_IDLE;
          end else begin
            rd_en       = 1'b1;
            rd_addr     = dmrq_pkg::text_addr(drain_slot, idx_inc[dmrq_pkg::LEN_W-1:0]);
            rd_idx_next = idx_inc[dmrq_pkg::LEN_W-1:0];
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    out_valid_next = out_load || (out_valid && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      text_mem[wr_addr] <= cmd.data;
    end
    if (rd_en) begin
      mem_q <= text_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < dmrq_pkg::MAX_MESSAGES; i++) begin
        msg_len[i] <= '0;
      end
    end else if (len_we) begin
      msg_len[fill_slot] <= fill_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_slot  <= '0;
      drain_slot <= '0;
      queued     <= '0;
      receiving  <= 1'b0;
      fill_len   <= '0;
      rd_idx     <= '0;
      rd_len     <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      fill_slot  <= fill_slot_next;
      drain_slot <= drain_slot_next;
      queued     <= queued_next;
      receiving  <= receiving_next;
      fill_len   <= fill_len_next;
      rd_idx     <= rd_idx_next;
      rd_len     <= rd_len_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status  <= out_status_next;
      out_byte    <= out_byte_next;
      out_last    <= out_last_next;
      out_waiting <= out_waiting_next;
    end
  end

  a_queued_bound: assert property (@(posedge clk) disable iff (rst)
    queued <= dmrq_pkg::CNT_W'(dmrq_pkg::MAX_MESSAGES))
    else $error("queued count above slot count");

  a_recv_has_room: assert property (@(posedge clk) disable iff (rst)
    receiving |-> has_room)
    else $error("receiving while all slots are queued");

  a_stream_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_STREAM) |-> (rd_len != '0 && rd_idx < rd_len && queued != '0))
    else $error("stream index outside the message");

  a_stream_no_pop: assert property (@(posedge clk) disable iff (rst)
    (state == S_STREAM) |-> !cmd_ready)
    else $error("command taken during read-out");

endmodule

### test/tb_delimited_message_receive_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_delimited_message_receive_queue_top
// Self-checking bench for the delimited message receive queue.
// ----------------------------------------------------------------------------
// Feeds line bytes and read commands through the input stream and tracks
// framing, the slot ring and every read-out in a predictor kept inside the
// bench. Each result item is checked field by field against the oldest
// predicted one. A short directed run covers the empty read, stray end marks,
// restart, empty messages and the full ring. Random framed traffic with
// noise, broken and overflowing messages follows, across several marker
// settings (extremes and equal marks) and with random idling on both streams.
// ----------------------------------------------------------------------------
module tb_delimited_message_receive_queue_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 72;
  localparam int MAX_PRINTS  = 20;

  typedef struct {
    logic       action;
    logic [7:0] data;
  } line_cmd_t;

  typedef struct {
    logic [1:0] status;
    logic [7:0] data;
    logic       last;
    logic [4:0] waiting;
  } msg_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = dmrq_pkg::CFG_START;
  logic [7:0]  cfg_data = 8'd0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tuser = dmrq_pkg::ACT_LINE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  line_cmd_t   cmd_q[$];
  msg_result_t result_q[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;
  int mismatches = 0;
  int items_in = 0;
  int results_seen = 0;
  int commits = 0;
  int overflows = 0;
  int full_rejects = 0;
  int empty_reads = 0;

  // predictor state
  logic [7:0] open_byte = dmrq_pkg::START_RESET;
  logic [7:0] close_byte = dmrq_pkg::END_RESET;
  logic [7:0] text_mem [dmrq_pkg::MAX_MESSAGES][dmrq_pkg::MAX_CHARS];
  int         slot_len [dmrq_pkg::MAX_MESSAGES];
  int         fill_slot = 0;
  int         drain_slot = 0;
  int         queued = 0;
  logic       receiving = 1'b0;

  delimited_message_receive_queue_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic log_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  task automatic frame_byte(input logic [7:0] b);
    int len;
    if (b == open_byte && queued < dmrq_pkg::MAX_MESSAGES) begin
      receiving = 1'b1;
      slot_len[fill_slot] = 0;
      return;
    end
    if (b == open_byte) begin
      full_rejects++;
    end
    if (b == close_byte) begin
      if (!receiving) begin
        return;
      end
      fill_slot = (fill_slot + 1) % dmrq_pkg::MAX_MESSAGES;
      if (queued < dmrq_pkg::MAX_MESSAGES) begin
        queued++;
      end
      receiving = 1'b0;
      commits++;
      return;
    end
    if (!receiving) begin
      return;
    end
    len = slot_len[fill_slot];
    if (len >= dmrq_pkg::MAX_CHARS) begin
      len = 0;
    end
    text_mem[fill_slot][len] = b;
    len++;
    if (len >= dmrq_pkg::MAX_CHARS) begin
      len = 0;
      receiving = 1'b0;
      overflows++;
    end
    slot_len[fill_slot] = len;
  endtask

  task automatic read_oldest();
    msg_result_t r;
    int len;
    int after;
    if (queued == 0) begin
      r = '{dmrq_pkg::ST_NONE, 8'd0, 1'b1, 5'd0};
      result_q.push_back(r);
      empty_reads++;
      return;
    end
    after = queued - 1;
    len = slot_len[drain_slot];
    if (len >= dmrq_pkg::MAX_CHARS) begin
      len = dmrq_pkg::MAX_CHARS - 1;
    end
    if (len == 0) begin
      r = '{dmrq_pkg::ST_EMPTY, 8'd0, 1'b1, 5'(after)};
      result_q.push_back(r);
    end else begin
      for (int i = 0; i < len; i++) begin
        r.status  = dmrq_pkg::ST_BYTE;
        r.data    = text_mem[drain_slot][i];
        r.last    = (i + 1 == len);
        r.waiting = (i + 1 == len) ? 5'(after) : 5'(queued);
        result_q.push_back(r);
      end
    end
    drain_slot = (drain_slot + 1) % dmrq_pkg::MAX_MESSAGES;
    queued = after;
  endtask

  // driver
  always @(posedge clk) begin
    line_cmd_t c;
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (!s_tvalid || s_tready) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          c = cmd_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= c.action;
          s_tdata  <= c.data;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    msg_result_t e;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        items_in++;
        if (s_tuser == dmrq_pkg::ACT_READ) begin
          read_oldest();
        end else begin
          frame_byte(s_tdata);
        end
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (result_q.size() == 0) begin
          log_mismatch($sformatf("result item with nothing expected, tdata %h", m_tdata));
        end else begin
          e = result_q.pop_front();
          if (m_tuser != e.status) begin
            log_mismatch($sformatf("status %0d, expected %0d", m_tuser, e.status));
          end
          if (m_tdata[7:0] != e.data) begin
            log_mismatch($sformatf("message byte %h, expected %h", m_tdata[7:0], e.data));
          end
          if (m_tdata[12:8] != e.waiting) begin
            log_mismatch($sformatf("waiting %0d, expected %0d", m_tdata[12:8], e.waiting));
          end
          if (m_tdata[15:13] != 3'd0) begin
            log_mismatch($sformatf("tdata pad bits %b not zero", m_tdata[15:13]));
          end
          if (m_tlast != e.last) begin
            log_mismatch($sformatf("tlast %b, expected %b", m_tlast, e.last));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, result_q.size());
      $display("** delimited_message_receive_queue_top: FAILED **");
      $finish;
    end
  end

  task automatic push_cmd(input logic action, input logic [7:0] data);
    line_cmd_t c;
    c.action = action;
    c.data   = data;
    cmd_q.push_back(c);
  endtask

  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if ($urandom_range(9) < 8) begin
      while (b == open_byte || b == close_byte) begin
        b = 8'($urandom_range(255));
      end
    end
    return b;
  endfunction

  task automatic random_traffic(input int n);
    int made;
    int r;
    int len;
    made = 0;
    while (made < n) begin
      r = $urandom_range(99);
      if (r < 50) begin
        push_cmd(dmrq_pkg::ACT_LINE, open_byte);
        made++;
        r = $urandom_range(99);
        if (r < 80) begin
          len = $urandom_range(6);
        end else if (r < 95) begin
          len = $urandom_range(dmrq_pkg::MAX_CHARS - 1, 7);
        end else begin
          len = $urandom_range(dmrq_pkg::MAX_CHARS + 4, dmrq_pkg::MAX_CHARS);
        end
        repeat (len) begin
          push_cmd(dmrq_pkg::ACT_LINE, body_byte());
          made++;
        end
        if ($urandom_range(9) != 0) begin
          push_cmd(dmrq_pkg::ACT_LINE, close_byte);
          made++;
        end
      end else if (r < 82) begin
        push_cmd(dmrq_pkg::ACT_READ, 8'($urandom_range(255)));
        made++;
      end else if (r < 90) begin
        push_cmd(dmrq_pkg::ACT_LINE, close_byte);
        made++;
      end else begin
        push_cmd(dmrq_pkg::ACT_LINE, 8'($urandom_range(255)));
        made++;
      end
    end
  endtask

  task automatic wait_drained();
    while (cmd_q.size() != 0 || s_tvalid || result_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (16) @(negedge clk);
  endtask

  task automatic write_marks(input logic [7:0] start_v, input logic [7:0] end_v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= dmrq_pkg::CFG_START;
    cfg_data  <= start_v;
    @(posedge clk);
    cfg_index <= dmrq_pkg::CFG_END;
    cfg_data  <= end_v;
    @(posedge clk);
    cfg_we <= 1'b0;
    open_byte  = start_v;
    close_byte = end_v;
    @(negedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int stall);
    send_idle_pct = send_pct;
    stall_pct     = stall;
  endtask

  initial begin
    foreach (slot_len[i]) begin
      slot_len[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty read, stray marks, restart, empty messages, full ring
    set_idling(0, 0);
    push_cmd(dmrq_pkg::ACT_READ, 8'hFF);
    push_cmd(dmrq_pkg::ACT_LINE, dmrq_pkg::END_RESET);
    push_cmd(dmrq_pkg::ACT_LINE, dmrq_pkg::START_RESET);
    push_cmd(dmrq_pkg::ACT_LINE, 8'h00);
    push_cmd(dmrq_pkg::ACT_LINE, 8'hFF);
    push_cmd(dmrq_pkg::ACT_LINE, dmrq_pkg::END_RESET);
    push_cmd(dmrq_pkg::ACT_LINE, dmrq_pkg::START_RESET);
    push_cmd(dmrq_pkg::ACT_LINE, dmrq_pkg::END_RESET);
    push_cmd(dmrq_pkg::ACT_LINE, dmrq_pkg::START_RESET);
    push_cmd(dmrq_pkg::ACT_LINE, 8'h61);
    push_cmd(dmrq_pkg::ACT_LINE, dmrq_pkg::START_RESET);
    push_cmd(dmrq_pkg::ACT_LINE, 8'h62);
    push_cmd(dmrq_pkg::ACT_LINE, dmrq_pkg::END_RESET);
    push_cmd(dmrq_pkg::ACT_LINE, dmrq_pkg::START_RESET);
    push_cmd(dmrq_pkg::ACT_LINE, dmrq_pkg::END_RESET);
    push_cmd(dmrq_pkg::ACT_LINE, dmrq_pkg::START_RESET);
    push_cmd(dmrq_pkg::ACT_LINE, 8'h63);
    push_cmd(dmrq_pkg::ACT_LINE, dmrq_pkg::END_RESET);
    repeat (5) push_cmd(dmrq_pkg::ACT_READ, 8'h00);
    wait_drained();

    random_traffic(PHASE_ITEMS);
    wait_drained();

    write_marks(8'h00, 8'hFF);
    set_idling(51, 0);
    random_traffic(PHASE_ITEMS);
    wait_drained();

    write_marks(8'h5A, 8'h5A);
    set_idling(0, 51);
    random_traffic(PHASE_ITEMS);
    wait_drained();

    write_marks(8'hFF, 8'h00);
    set_idling(30, 30);
    random_traffic(PHASE_ITEMS);
    wait_drained();

    write_marks(8'($urandom_range(127)), 8'($urandom_range(255, 128)));
    set_idling(30, 30);
    random_traffic(PHASE_ITEMS / 2);
    set_idling(0, 0);
    random_traffic(PHASE_ITEMS / 2);
    wait_drained();

    $display("%0d items in, %0d result items checked in %0d cycles", items_in, results_seen,
             cycles);
    $display("%0d messages committed, %0d overflowed, %0d starts refused on a full ring,",
             commits, overflows, full_rejects);
    $display("%0d reads of an empty queue", empty_reads);
    if (mismatches == 0) begin
      $display("** delimited_message_receive_queue_top: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** delimited_message_receive_queue_top: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
rtl/dmrq_pkg.sv
rtl/dmrq_front.sv
rtl/dmrq_cmd_queue.sv
rtl/dmrq_back.sv
rtl/delimited_message_receive_queue_top.sv
test/tb_delimited_message_receive_queue_top.sv
